// ===== rtl/core/framed_packet_deframer_assert.svh =====
// assertion macros shared by the deframer checker
`ifndef FRAMED_PACKET_DEFRAMER_ASSERT_SVH
`define FRAMED_PACKET_DEFRAMER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define DFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dfr_pkg.sv =====
// types and constants of the framed packet deframer
`default_nettype none

package dfr_pkg;

  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_ACCEPT  = 2'd1,
    EV_REJECT  = 2'd2,
    EV_COMMAND = 2'd3
  } dfr_event_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_VERSION  = 2'd1,
    ERR_LENGTH   = 2'd2,
    ERR_CHECKSUM = 2'd3
  } dfr_err_t;

  localparam logic [1:0] CFG_START_IDX   = 2'd0;
  localparam logic [1:0] CFG_END_IDX     = 2'd1;
  localparam logic [1:0] CFG_VERSION_IDX = 2'd2;
  localparam logic [1:0] CFG_MAX_IDX     = 2'd3;

  localparam logic [7:0]  START_RESET   = 8'h02;
  localparam logic [7:0]  END_RESET     = 8'h03;
  localparam logic [7:0]  VERSION_RESET = 8'h01;
  localparam logic [15:0] MAX_RESET     = 16'd256;

  localparam logic [7:0] CMD_LOW  = 8'h10;
  localparam logic [7:0] CMD_HIGH = 8'h8F;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [7:0]  version_byte;
    logic [15:0] max_payload;
  } dfr_cfg_t;

  typedef struct packed {
    logic        valid;
    dfr_event_t  event_kind;
    logic [7:0]  data_byte;
    logic [7:0]  seq_number;
    dfr_err_t    error_code;
    logic [15:0] frame_length;
  } dfr_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/dfr_if.sv =====
// byte input and event output channel interfaces
`default_nettype none

interface dfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  data_byte;
  logic [7:0]  seq_number;
  logic [1:0]  error_code;
  logic [15:0] frame_length;

  modport source (output valid, output event_kind, output data_byte, output seq_number,
                  output error_code, output frame_length, input ready);
  modport sink   (input valid, input event_kind, input data_byte, input seq_number,
                  input error_code, input frame_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dfr_parser.sv =====
// frame parser state machine and per-byte event decode
`default_nettype none

module dfr_parser
  import dfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [7:0]  rx_byte,
  input  wire dfr_cfg_t    cfg,
  output dfr_result_t      res
);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_HEADER  = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_CHECK   = 5'b01000,
    PH_END     = 5'b10000
  } dfr_phase_t;

  dfr_phase_t  phase_r, phase_nxt;
  logic [1:0]  header_count_r, header_count_nxt;
  logic [7:0]  version_seen_r, version_seen_nxt;
  logic [7:0]  seq_held_r, seq_held_nxt;
  logic [7:0]  length_high_r, length_high_nxt;
  logic [15:0] payload_length_r, payload_length_nxt;
  logic [15:0] payload_count_r, payload_count_nxt;
  logic [7:0]  running_xor_r, running_xor_nxt;

  logic [15:0] hdr_length;
  logic [15:0] count_inc;
  logic        is_start;
  logic        is_command;

  assign hdr_length = {length_high_r, rx_byte};
  assign count_inc  = payload_count_r + 16'd1;
  assign is_start   = (rx_byte == cfg.start_byte);
  assign is_command = (rx_byte >= CMD_LOW) && (rx_byte <= CMD_HIGH);

  always_comb begin
    phase_nxt          = phase_r;
    header_count_nxt   = header_count_r;
    version_seen_nxt   = version_seen_r;
    seq_held_nxt       = seq_held_r;
    length_high_nxt    = length_high_r;
    payload_length_nxt = payload_length_r;
    payload_count_nxt  = payload_count_r;
    running_xor_nxt    = running_xor_r;
    res                = '0;

    case (phase_r)
      PH_HEADER: begin
        case (header_count_r)
          2'd0: begin
            version_seen_nxt = rx_byte;
            header_count_nxt = 2'd1;
          end
          2'd1: begin
            seq_held_nxt     = rx_byte;
            header_count_nxt = 2'd2;
          end
          2'd2: begin
            length_high_nxt  = rx_byte;
            header_count_nxt = 2'd3;
          end
          default: begin
            header_count_nxt   = 2'd0;
            payload_length_nxt = hdr_length;
            payload_count_nxt  = '0;
            running_xor_nxt    = '0;
            res.seq_number     = seq_held_r;
            res.frame_length   = hdr_length;
            res.event_kind     = EV_REJECT;
            if (version_seen_r != cfg.version_byte) begin
              phase_nxt      = PH_IDLE;
              res.valid      = 1'b1;
              res.error_code = ERR_VERSION;
            end else if (hdr_length > cfg.max_payload) begin
              phase_nxt      = PH_IDLE;
              res.valid      = 1'b1;
              res.error_code = ERR_LENGTH;
            end else begin
              phase_nxt = (hdr_length == 16'd0) ? PH_CHECK : PH_PAYLOAD;
            end
          end
        endcase
      end

      PH_PAYLOAD: begin
        running_xor_nxt   = running_xor_r ^ rx_byte;
        payload_count_nxt = count_inc;
        if (count_inc >= payload_length_r) begin
          phase_nxt = PH_CHECK;
        end
        res.valid        = 1'b1;
        res.event_kind   = EV_PAYLOAD;
        res.data_byte    = rx_byte;
        res.seq_number   = seq_held_r;
        res.frame_length = payload_length_r;
      end

      PH_CHECK: begin
        res.valid        = 1'b1;
        res.seq_number   = seq_held_r;
        res.frame_length = payload_length_r;
        if (running_xor_r != rx_byte) begin
          phase_nxt      = PH_IDLE;
          res.event_kind = EV_REJECT;
          res.error_code = ERR_CHECKSUM;
        end else begin
          phase_nxt      = PH_END;
          res.event_kind = EV_ACCEPT;
        end
      end

      PH_END: begin
        // end byte wins when start and end are the same value
        if (rx_byte != cfg.end_byte && is_start) begin
          phase_nxt          = PH_HEADER;
          header_count_nxt   = '0;
          payload_length_nxt = '0;
          payload_count_nxt  = '0;
          running_xor_nxt    = '0;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end

      default: begin
        // idle, and any code that is not one-hot
        phase_nxt = PH_IDLE;
        if (is_start) begin
          phase_nxt          = PH_HEADER;
          header_count_nxt   = '0;
          payload_length_nxt = '0;
          payload_count_nxt  = '0;
          running_xor_nxt    = '0;
        end else if (is_command) begin
          res.valid      = 1'b1;
          res.event_kind = EV_COMMAND;
          res.data_byte  = rx_byte;
        end
      end
    endcase

    res.valid = res.valid & accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      header_count_r   <= '0;
      version_seen_r   <= '0;
      seq_held_r       <= '0;
      length_high_r    <= '0;
      payload_length_r <= '0;
      payload_count_r  <= '0;
      running_xor_r    <= '0;
    end else if (accept) begin
      phase_r          <= phase_nxt;
      header_count_r   <= header_count_nxt;
      version_seen_r   <= version_seen_nxt;
      seq_held_r       <= seq_held_nxt;
      length_high_r    <= length_high_nxt;
      payload_length_r <= payload_length_nxt;
      payload_count_r  <= payload_count_nxt;
      running_xor_r    <= running_xor_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/framed_packet_deframer.sv =====
// framed packet deframer: parses start/header/payload/check/end frames from a byte stream
//
// in_ch carries one received byte per transaction; out_ch carries at most one event per
// input byte: a payload byte, frame accepted, frame rejected (with error code) or a
// single-byte command seen while idle. end bytes give none; header bytes, only a reject.
// an event appears on out_ch the cycle after its byte is taken.
// throughput: one byte per cycle unless out_ch stalls; the parser state updates in
// the same cycle the byte is taken and the event lands in a single output register.
// in_ch.ready stays high while the output register is empty or being drained, so a
// stalled receiver holds the pending event stable and blocks further bytes only
// while that event waits.
// reset (rst_n low at a clock edge): parser back to idle, output register empty,
// configuration registers back to start 0x02, end 0x03, version 0x01, max 256.
// configuration: cfg_we writes cfg_data to register cfg_index (0 start, 1 end,
// 2 version, 3 max payload); write only while no frame is being parsed.
// a rejected frame means any payload already passed out must be dropped downstream.
`default_nettype none

module framed_packet_deframer
  import dfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  dfr_in_if.sink           in_ch,
  dfr_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  dfr_cfg_t    cfg_r;
  dfr_result_t res;
  logic        in_accept;

  logic        out_valid_r;
  dfr_event_t  out_kind_r;
  logic [7:0]  out_data_r;
  logic [7:0]  out_seq_r;
  dfr_err_t    out_err_r;
  logic [15:0] out_len_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte   <= START_RESET;
      cfg_r.end_byte     <= END_RESET;
      cfg_r.version_byte <= VERSION_RESET;
      cfg_r.max_payload  <= MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_IDX:   cfg_r.start_byte   <= cfg_data[7:0];
        CFG_END_IDX:     cfg_r.end_byte     <= cfg_data[7:0];
        CFG_VERSION_IDX: cfg_r.version_byte <= cfg_data[7:0];
        CFG_MAX_IDX:     cfg_r.max_payload  <= cfg_data;
        default: ;
      endcase
    end
  end

  dfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .rx_byte (in_ch.rx_byte),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= res.valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // event fields load only with a new transaction that produces an event
  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_kind_r <= res.event_kind;
      out_data_r <= res.data_byte;
      out_seq_r  <= res.seq_number;
      out_err_r  <= res.error_code;
      out_len_r  <= res.frame_length;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_kind   = out_kind_r;
  assign out_ch.data_byte    = out_data_r;
  assign out_ch.seq_number   = out_seq_r;
  assign out_ch.error_code   = out_err_r;
  assign out_ch.frame_length = out_len_r;

endmodule

`default_nettype wire

// ===== rtl/core/dfr_checker.sv =====
// port-level checker for the deframer, bound to the top level
`default_nettype none

`include "framed_packet_deframer_assert.svh"

module dfr_checker
  import dfr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  event_kind,
  input wire logic [7:0]  data_byte,
  input wire logic [7:0]  seq_number,
  input wire logic [1:0]  error_code,
  input wire logic [15:0] frame_length
);

  `DFR_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(event_kind) && $stable(data_byte) && $stable(error_code), "stalled event changed")
  `DFR_ASSERT_IMP(a_command_clean, out_valid && event_kind == EV_COMMAND, seq_number == 8'd0 && error_code == ERR_NONE && frame_length == 16'd0, "command event carries frame fields")
  `DFR_ASSERT_IMP(a_reject_code, out_valid && event_kind == EV_REJECT, error_code != ERR_NONE && data_byte == 8'd0, "reject without error code")
  `DFR_ASSERT_IMP(a_error_only_reject, out_valid && event_kind != EV_REJECT, error_code == ERR_NONE, "error code on non-reject event")

endmodule

bind framed_packet_deframer dfr_checker u_dfr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .event_kind   (out_ch.event_kind),
  .data_byte    (out_ch.data_byte),
  .seq_number   (out_ch.seq_number),
  .error_code   (out_ch.error_code),
  .frame_length (out_ch.frame_length)
);

`default_nettype wire
